// ===== design/rlb_pkg.sv =====
package rlb_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam logic [16:0] ROUND_U = 17'h00080;
    localparam logic signed [17:0] ROUND_S = 18'sh00080;

    typedef struct packed {
        logic [CHAN_W-1:0] mix;
        logic [CHAN_W-1:0] src;
        logic [CHAN_W-1:0] dst;
    } t_lane_out;

endpackage

// ===== design/rlb_lane.sv =====
module rlb_lane (
    input  logic              i_clk,
    input  logic [7:0]        i_src,
    input  logic [7:0]        i_dst,
    input  logic [7:0]        i_opacity,
    input  logic              i_mult,
    output rlb_pkg::t_lane_out o_lane
);
    import rlb_pkg::*;

    logic [16:0]        r_t1;
    logic [7:0]         r_s1, r_d1, r_op1;
    logic               r_m1;
    logic [8:0]         r_diff2;
    logic [7:0]         r_s2, r_d2, r_op2;
    logic signed [17:0] r_t3;
    logic [7:0]         r_s3, r_d3;
    t_lane_out          r_out;

    logic [16:0]        n_u1;
    logic [7:0]         n_s2;
    logic signed [17:0] n_t3;
    logic signed [17:0] n_u3;

    // rounded product finish, unsigned source multiply
    assign n_u1 = {8'd0, r_t1[16:8]} + r_t1;
    assign n_s2 = r_m1 ? n_u1[15:8] : r_s1;

    assign n_t3 = $signed(r_diff2) * $signed({1'b0, r_op2}) + ROUND_S;
    // rounded product finish, signed difference
    assign n_u3 = (r_t3 >>> 8) + r_t3;

    always_ff @(posedge i_clk) begin
        r_t1    <= 17'({8'd0, i_dst} * {8'd0, i_src}) + ROUND_U;
        r_s1    <= i_src;
        r_d1    <= i_dst;
        r_op1   <= i_opacity;
        r_m1    <= i_mult;

        r_s2    <= n_s2;
        r_d2    <= r_d1;
        r_op2   <= r_op1;
        r_diff2 <= {1'b0, n_s2} - {1'b0, r_d1};

        r_t3    <= n_t3;
        r_s3    <= r_s2;
        r_d3    <= r_d2;

        r_out.mix <= r_d3 + n_u3[15:8];
        r_out.src <= r_s3;
        r_out.dst <= r_d3;
    end

    assign o_lane = r_out;

endmodule

// ===== design/rgba_layer_blend_core.sv =====
// an accepted start passes through r_vld[0] to r_vld[3] and r_ov to the o_valid strobe
// throughput: one word per cycle; busy is never raised
// the receiver cannot stall; each result is held for exactly one cycle
// each channel lane holds two multiply stages
// synchronous active-low reset clears the valid pipeline only
module rgba_layer_blend_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_src_red,
    input  logic [7:0] i_src_green,
    input  logic [7:0] i_src_blue,
    input  logic [7:0] i_src_alpha,
    input  logic [7:0] i_dst_red,
    input  logic [7:0] i_dst_green,
    input  logic [7:0] i_dst_blue,
    input  logic [7:0] i_dst_alpha,
    input  logic [7:0] i_opacity,
    input  logic       i_blend_mode,
    output logic       o_valid,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha
);
    import rlb_pkg::*;

    t_lane_out  w_red, w_green, w_blue, w_alpha;
    logic [3:0] r_vld;
    logic       r_ov;
    logic [7:0] r_red, r_green, r_blue, r_alpha;
    logic [7:0] n_red, n_green, n_blue;
    logic       n_zero;

    assign busy = 1'b0;

    rlb_lane u_red (
        .i_clk(i_clk), .i_src(i_src_red), .i_dst(i_dst_red),
        .i_opacity(i_opacity), .i_mult(i_blend_mode), .o_lane(w_red)
    );
    rlb_lane u_green (
        .i_clk(i_clk), .i_src(i_src_green), .i_dst(i_dst_green),
        .i_opacity(i_opacity), .i_mult(i_blend_mode), .o_lane(w_green)
    );
    rlb_lane u_blue (
        .i_clk(i_clk), .i_src(i_src_blue), .i_dst(i_dst_blue),
        .i_opacity(i_opacity), .i_mult(i_blend_mode), .o_lane(w_blue)
    );
    rlb_lane u_alpha (
        .i_clk(i_clk), .i_src(i_src_alpha), .i_dst(i_dst_alpha),
        .i_opacity(i_opacity), .i_mult(1'b0), .o_lane(w_alpha)
    );

    // empty destination, then empty source, then mixed
    always_comb begin
        if (w_alpha.dst == 8'd0) begin
            n_red   = w_red.src;
            n_green = w_green.src;
            n_blue  = w_blue.src;
        end else if (w_alpha.src == 8'd0) begin
            n_red   = w_red.dst;
            n_green = w_green.dst;
            n_blue  = w_blue.dst;
        end else begin
            n_red   = w_red.mix;
            n_green = w_green.mix;
            n_blue  = w_blue.mix;
        end
    end

    assign n_zero = (w_alpha.mix == 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_vld <= {r_vld[2:0], start & ~busy};
            r_ov  <= r_vld[3];
        end
        r_red   <= n_zero ? 8'd0 : n_red;
        r_green <= n_zero ? 8'd0 : n_green;
        r_blue  <= n_zero ? 8'd0 : n_blue;
        r_alpha <= w_alpha.mix;
    end

    assign o_valid     = r_ov;
    assign o_out_red   = r_red;
    assign o_out_green = r_green;
    assign o_out_blue  = r_blue;
    assign o_out_alpha = r_alpha;

    a_zero_alpha: assert property (@(posedge i_clk)
        (o_valid && o_out_alpha == 8'd0) |->
        (o_out_red == 8'd0 && o_out_green == 8'd0 && o_out_blue == 8'd0))
        else $error("zero alpha word with nonzero color");

    a_vld_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |=> r_vld[1])
        else $error("valid lost in pipeline");

    a_out_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |=> o_valid)
        else $error("result strobe missing");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[3] |=> !o_valid)
        else $error("result strobe without word");

endmodule

// ===== tb/rgba_layer_blend_core_test.sv =====
module rgba_layer_blend_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [rlb_pkg::CHAN_W-1:0] chan_t;

    localparam logic MODE_NORMAL   = 1'b0;
    localparam logic MODE_MULTIPLY = 1'b1;
    localparam int   BLEND_ROUND   = 'h80;
    localparam int   STALL_LIMIT   = 400;
    localparam int   RANDOM_WORDS  = 700;

    typedef struct packed {
        chan_t sr, sg, sb, sa;
        chan_t dr, dg, db, da;
        chan_t opacity;
        logic  mode;
    } blend_word_t;

    typedef struct packed {
        chan_t r, g, b, a;
    } pixel_t;

    typedef struct packed {
        blend_word_t word;
        logic        known;
        pixel_t      want;
    } blend_row_t;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    chan_t i_src_red, i_src_green, i_src_blue, i_src_alpha;
    chan_t i_dst_red, i_dst_green, i_dst_blue, i_dst_alpha;
    chan_t i_opacity;
    logic  i_blend_mode;
    logic  o_valid;
    chan_t o_out_red, o_out_green, o_out_blue, o_out_alpha;

    pixel_t pending_px[$];
    pixel_t want_px, got_px;
    int     mismatch_cnt = 0;
    int     stall_cycles = 0;

    // typed rows can be read off by hand, the rest go through the predictor
    blend_row_t dir_rows[18] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_NORMAL}, 1'b1, '{0, 0, 0, 0}},
        '{'{255, 255, 255, 255, 255, 255, 255, 255, 255, MODE_NORMAL}, 1'b1,
          '{255, 255, 255, 255}},
        '{'{10, 20, 30, 255, 1, 2, 3, 0, 255, MODE_NORMAL}, 1'b1, '{10, 20, 30, 255}},
        '{'{9, 9, 9, 0, 40, 50, 60, 200, 0, MODE_NORMAL}, 1'b1, '{40, 50, 60, 200}},
        '{'{1, 2, 3, 4, 100, 110, 120, 130, 0, MODE_NORMAL}, 1'b1,
          '{100, 110, 120, 130}},
        '{'{200, 0, 255, 77, 10, 255, 0, 33, 255, MODE_NORMAL}, 1'b1,
          '{200, 0, 255, 77}},
        '{'{5, 6, 7, 0, 8, 9, 10, 0, 255, MODE_NORMAL}, 1'b1, '{0, 0, 0, 0}},
        '{'{255, 0, 128, 255, 255, 255, 64, 255, 255, MODE_MULTIPLY}, 1'b1,
          '{255, 0, 32, 255}},
        '{'{200, 100, 50, 255, 0, 0, 0, 0, 255, MODE_MULTIPLY}, 1'b1, '{0, 0, 0, 255}},
        '{'{255, 255, 255, 255, 255, 255, 255, 255, 255, MODE_MULTIPLY}, 1'b1,
          '{255, 255, 255, 255}},
        '{'{11, 22, 33, 0, 44, 55, 66, 0, 200, MODE_MULTIPLY}, 1'b1, '{0, 0, 0, 0}},
        '{'{77, 88, 99, 0, 12, 34, 56, 180, 128, MODE_MULTIPLY}, 1'b0, '0},
        '{'{255, 0, 255, 128, 0, 255, 0, 128, 128, MODE_NORMAL}, 1'b0, '0},
        '{'{255, 255, 255, 255, 0, 0, 0, 255, 1, MODE_NORMAL}, 1'b0, '0},
        '{'{0, 0, 0, 255, 255, 255, 255, 255, 254, MODE_NORMAL}, 1'b0, '0},
        '{'{170, 85, 240, 255, 15, 200, 100, 1, 128, MODE_MULTIPLY}, 1'b0, '0},
        '{'{'h55, 'hAA, 'h55, 'hAA, 'hAA, 'h55, 'hAA, 'h55, 'hAA, MODE_NORMAL}, 1'b0, '0},
        '{'{'hAA, 'h55, 'hAA, 'h55, 'h55, 'hAA, 'h55, 'hAA, 'h55, MODE_MULTIPLY}, 1'b0, '0}
    };

    rgba_layer_blend_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_src_red    (i_src_red),
        .i_src_green  (i_src_green),
        .i_src_blue   (i_src_blue),
        .i_src_alpha  (i_src_alpha),
        .i_dst_red    (i_dst_red),
        .i_dst_green  (i_dst_green),
        .i_dst_blue   (i_dst_blue),
        .i_dst_alpha  (i_dst_alpha),
        .i_opacity    (i_opacity),
        .i_blend_mode (i_blend_mode),
        .o_valid      (o_valid),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_out_alpha  (o_out_alpha)
    );

    always #6 i_clk = ~i_clk;

    // rounded 8-bit product, arithmetic shifts floor the signed differences
    function automatic int mul_round(int a, int b);
        int t;
        t = a * b + BLEND_ROUND;
        return ((t >>> 8) + t) >>> 8;
    endfunction

    function automatic pixel_t blend_pixel(blend_word_t w);
        int     s[3], d[3], c[3];
        int     sa, da, op, a;
        pixel_t px;
        s  = '{int'(w.sr), int'(w.sg), int'(w.sb)};
        d  = '{int'(w.dr), int'(w.dg), int'(w.db)};
        sa = w.sa;
        da = w.da;
        op = w.opacity;
        for (int i = 0; i < 3; i++) begin
            if (w.mode == MODE_MULTIPLY) begin
                s[i] = mul_round(d[i], s[i]) & 'hFF;
            end
            if (da == 0) begin
                c[i] = s[i];
            end else if (sa == 0) begin
                c[i] = d[i];
            end else begin
                c[i] = d[i] + mul_round(s[i] - d[i], op);
            end
        end
        a = da + mul_round(sa - da, op);
        if (a == 0) begin
            px = '0;
        end else begin
            px = '{chan_t'(c[0]), chan_t'(c[1]), chan_t'(c[2]), chan_t'(a)};
        end
        return px;
    endfunction

    function automatic chan_t corner_byte();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return chan_t'($urandom_range(255));
        endcase
    endfunction

    function automatic blend_word_t rand_word();
        blend_word_t w;
        w.sr      = chan_t'($urandom_range(255));
        w.sg      = chan_t'($urandom_range(255));
        w.sb      = corner_byte();
        w.sa      = corner_byte();
        w.dr      = chan_t'($urandom_range(255));
        w.dg      = chan_t'($urandom_range(255));
        w.db      = corner_byte();
        w.da      = corner_byte();
        w.opacity = corner_byte();
        w.mode    = $urandom_range(1) ? MODE_MULTIPLY : MODE_NORMAL;
        return w;
    endfunction

    function automatic int idle_gap(int pct);
        int n;
        n = 0;
        while (n < 40 && $urandom_range(99) < pct) begin
            n++;
        end
        return n;
    endfunction

    task automatic send_word(input blend_word_t w, input logic known, input pixel_t want,
                             input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_src_red    <= w.sr;
        i_src_green  <= w.sg;
        i_src_blue   <= w.sb;
        i_src_alpha  <= w.sa;
        i_dst_red    <= w.dr;
        i_dst_green  <= w.dg;
        i_dst_blue   <= w.db;
        i_dst_alpha  <= w.da;
        i_opacity    <= w.opacity;
        i_blend_mode <= w.mode;
        start        <= 1'b1;
        do @(negedge i_clk); while (busy !== 1'b0);
        @(posedge i_clk);
        pending_px.push_back(known ? want : blend_pixel(w));
    endtask

    // result check and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && (o_valid === 1'b1 || (start === 1'b1 && busy === 1'b0))) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            got_px = '{o_out_red, o_out_green, o_out_blue, o_out_alpha};
            if (pending_px.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected word: r=%h g=%h b=%h a=%h",
                             got_px.r, got_px.g, got_px.b, got_px.a);
                end
            end else begin
                want_px = pending_px.pop_front();
                if (got_px !== want_px) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("mismatch: expected r=%h g=%h b=%h a=%h, got r=%h g=%h b=%h a=%h",
                                 want_px.r, want_px.g, want_px.b, want_px.a,
                                 got_px.r, got_px.g, got_px.b, got_px.a);
                    end
                end
            end
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int pct;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_src_red    <= '0;
        i_src_green  <= '0;
        i_src_blue   <= '0;
        i_src_alpha  <= '0;
        i_dst_red    <= '0;
        i_dst_green  <= '0;
        i_dst_blue   <= '0;
        i_dst_alpha  <= '0;
        i_opacity    <= '0;
        i_blend_mode <= MODE_NORMAL;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].word, dir_rows[i].known, dir_rows[i].want, idle_gap(11));
        end

        // hold off until the pipeline has drained
        start <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);

        for (int k = 0; k < RANDOM_WORDS; k++) begin
            pct = (k < 230) ? 11 : (k < 460) ? 68 : 0;
            send_word(rand_word(), 1'b0, '0, idle_gap(pct));
        end
        start <= 1'b0;

        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_px.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/rlb_pkg.sv
design/rlb_lane.sv
design/rgba_layer_blend_core.sv
tb/rgba_layer_blend_core_test.sv
